[hdl/lspq_pkg.sv]
`timescale 1ns / 1ps
package lspq_pkg;

  localparam int DEPTH   = 16;
  localparam int ID_BITS = 16;
  localparam int PRIO_W  = 8;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OUT_ID_W = 16;
  localparam int OCC_W    = 5;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_LIST    = 2'd1,
    ACT_EXTRACT = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_EXTRACTED = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_LISTED    = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] entry_id;
    logic [7:0]  entry_priority;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_id;
    logic [7:0]  out_priority;
    logic [4:0]  occupancy;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [PRIO_W-1:0]  prio;
  } slot_t;

  typedef struct packed {
    logic ins;
    logic empty;
    logic list_init;
    logic scan_init;
    logic scan;
    logic sh_init;
    logic shift;
    logic ext_done;
    logic list;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic idx_end;
    logic nxt_end;
  } sts_t;

endpackage

[hdl/lspq_dp.sv]
`timescale 1ns / 1ps
module lspq_dp
  import lspq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic res_valid_o,
  output rsp_t rsp_o
);

  slot_t slots_q [DEPTH];

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] nxt;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  slot_t            best_q, best_d;
  logic [IDX_W-1:0] rd_addr;
  slot_t            rd;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;
  logic             res_valid_q, res_valid_d;
  rsp_t             rsp_q, rsp_d;

  assign nxt = idx_q + CNT_W'(1);

  always_comb begin
    if (cmd_i.scan_init) begin
      rd_addr = '0;
    end else if (cmd_i.shift) begin
      rd_addr = nxt[IDX_W-1:0];
    end else begin
      rd_addr = idx_q[IDX_W-1:0];
    end
  end

  assign rd = slots_q[rd_addr];

  assign sts_o.empty   = (count_q == '0);
  assign sts_o.idx_end = (idx_q == count_q);
  assign sts_o.nxt_end = (nxt == count_q);

  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q[IDX_W-1:0];
    wr_data     = rd;
    res_valid_d = 1'b0;
    rsp_d       = '0;
    rsp_d.last  = 1'b1;
    rsp_d.occupancy = OCC_W'(count_q);

    if (cmd_i.ins) begin
      res_valid_d = 1'b1;
      if (count_q == CNT_W'(DEPTH)) begin
        rsp_d.status = ST_FULL;
      end else begin
        wr_en           = 1'b1;
        wr_addr         = count_q[IDX_W-1:0];
        wr_data.id      = ID_BITS'(req_i.entry_id);
        wr_data.prio    = req_i.entry_priority;
        count_d         = count_q + CNT_W'(1);
        rsp_d.status    = ST_INSERTED;
        rsp_d.occupancy = OCC_W'(count_d);
      end
    end

    if (cmd_i.empty) begin
      res_valid_d  = 1'b1;
      rsp_d.status = ST_EMPTY;
    end

    if (cmd_i.list_init) begin
      idx_d = '0;
    end

    if (cmd_i.scan_init) begin
      best_d     = rd;
      best_idx_d = '0;
      idx_d      = CNT_W'(1);
    end

    if (cmd_i.scan) begin
      if (rd.prio < best_q.prio) begin
        best_d     = rd;
        best_idx_d = idx_q[IDX_W-1:0];
      end
      idx_d = nxt;
    end

    if (cmd_i.sh_init) begin
      idx_d = CNT_W'(best_idx_q);
    end

    if (cmd_i.shift) begin
      wr_en   = 1'b1;
      wr_addr = idx_q[IDX_W-1:0];
      wr_data = rd;
      idx_d   = nxt;
    end

    if (cmd_i.ext_done) begin
      count_d            = count_q - CNT_W'(1);
      res_valid_d        = 1'b1;
      rsp_d.status       = ST_EXTRACTED;
      rsp_d.out_id       = OUT_ID_W'(best_q.id);
      rsp_d.out_priority = best_q.prio;
      rsp_d.occupancy    = OCC_W'(count_d);
    end

    if (cmd_i.list) begin
      res_valid_d        = 1'b1;
      rsp_d.status       = ST_LISTED;
      rsp_d.out_id       = OUT_ID_W'(rd.id);
      rsp_d.out_priority = rd.prio;
      rsp_d.last         = sts_o.nxt_end;
      idx_d              = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    rsp_q      <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slots_q[wr_addr] <= wr_data;
    end
  end

  assign res_valid_o = res_valid_q;
  assign rsp_o       = rsp_q;

endmodule

[hdl/lspq_ctrl.sv]
`timescale 1ns / 1ps
module lspq_ctrl
  import lspq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] action_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   accept;

  assign accept = start_i && !busy_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_INSERT: begin
              cmd_o.ins = 1'b1;
            end
            ACT_LIST: begin
              cmd_o.empty     = sts_i.empty;
              cmd_o.list_init = !sts_i.empty;
            end
            ACT_EXTRACT: begin
              cmd_o.empty     = sts_i.empty;
              cmd_o.scan_init = !sts_i.empty;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.sh_init = sts_i.idx_end;
        cmd_o.scan    = !sts_i.idx_end;
      end
      S_SHIFT: begin
        cmd_o.ext_done = sts_i.nxt_end;
        cmd_o.shift    = !sts_i.nxt_end;
      end
      S_LIST: begin
        cmd_o.list = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_o.list_init) begin
            state_q <= S_LIST;
            busy_q  <= 1'b1;
          end else if (cmd_o.scan_init) begin
            state_q <= S_SCAN;
            busy_q  <= 1'b1;
          end
        end
        S_SCAN: begin
          if (sts_i.idx_end) begin
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (sts_i.nxt_end) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
          end
        end
        S_LIST: begin
          if (sts_i.nxt_end) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;

endmodule

[hdl/linear_scan_priority_queue_top.sv]
// Insert and empty replies: word shown in the cycle after start is taken; next start in that cycle.
// List of N entries: N words, one per cycle, the first once the controller is in S_LIST.
// Extract of N entries with the winner in slot B: the single slot read port is used once
// per cycle, first for the scan of all N entries and then for the shift-down from slot B.
// Reset clears the entry count and the controller at once; slot storage is not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module linear_scan_priority_queue_top
  import lspq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output rsp_t rsp_o
);

  cmd_t cmd;
  sts_t sts;

  lspq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (req_i.action),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  lspq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

[hdl/lspq_chk.sv]
`timescale 1ns / 1ps
module lspq_chk
  import lspq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic res_valid_o,
  input rsp_t rsp_o
);

  logic acc;
  assign acc = start && !busy;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (rsp_o.occupancy <= OCC_W'(DEPTH)))
    else $error("occupancy beyond depth");

  a_insert_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && req_i.action == ACT_INSERT) |=>
      (res_valid_o && rsp_o.last &&
       (rsp_o.status == ST_INSERTED || rsp_o.status == ST_FULL)))
    else $error("insert word missing");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && rsp_o.status != ST_LISTED) |-> rsp_o.last)
    else $error("single word not marked last");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (rsp_o.status == ST_INSERTED || rsp_o.status == ST_FULL ||
                     rsp_o.status == ST_EMPTY))
      |-> (rsp_o.out_id == '0 && rsp_o.out_priority == '0))
    else $error("payload not zero");

  a_unused_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && req_i.action == ACT_UNUSED) |=> (!res_valid_o && !busy))
    else $error("unused action produced work");

endmodule

bind linear_scan_priority_queue_top lspq_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .res_valid_o (res_valid_o),
  .rsp_o       (rsp_o)
);

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import lspq_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  rsp_t rsp_o;

  linear_scan_priority_queue_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .rsp_o      (rsp_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [ID_BITS-1:0] held_id[DEPTH];
  logic [PRIO_W-1:0] held_prio[DEPTH];
  int held_count = 0;

  rsp_t pending_words[$];
  int fault_count = 0;
  int idle_cycles = 0;
  int words_sent = 0;
  int words_checked = 0;
  int full_seen = 0;
  int empty_seen = 0;
  int extract_seen = 0;
  int longest_list = 0;

  task automatic push_word(input logic [2:0] status, input logic [15:0] id,
                           input logic [7:0] prio, input logic last);
    rsp_t w;
    w.status = status;
    w.out_id = id;
    w.out_priority = prio;
    w.occupancy = OCC_W'(held_count);
    w.last = last;
    pending_words.push_back(w);
  endtask

  task automatic queue_request(input req_t r);
    int best;
    case (r.action)
      ACT_INSERT: begin
        if (held_count >= DEPTH) begin
          push_word(ST_FULL, '0, '0, 1'b1);
        end else begin
          held_id[held_count] = r.entry_id;
          held_prio[held_count] = r.entry_priority;
          held_count++;
          push_word(ST_INSERTED, '0, '0, 1'b1);
        end
      end
      ACT_LIST: begin
        if (held_count == 0) begin
          push_word(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < held_count; i++)
            push_word(ST_LISTED, held_id[i], held_prio[i], i == held_count - 1);
          if (held_count > longest_list) longest_list = held_count;
        end
      end
      ACT_EXTRACT: begin
        if (held_count == 0) begin
          push_word(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          best = 0;
          for (int i = 1; i < held_count; i++)
            if (held_prio[i] < held_prio[best]) best = i;
          held_count--;
          push_word(ST_EXTRACTED, held_id[best], held_prio[best], 1'b1);
          for (int i = best; i < held_count; i++) begin
            held_id[i] = held_id[i + 1];
            held_prio[i] = held_prio[i + 1];
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_word(input rsp_t got);
    rsp_t exp;
    if (pending_words.size() == 0) begin
      note_fault($sformatf("unexpected word st=%0d id=%h pr=%h occ=%0d last=%b",
                           got.status, got.out_id, got.out_priority, got.occupancy,
                           got.last));
    end else begin
      exp = pending_words.pop_front();
      words_checked++;
      case (exp.status)
        ST_FULL:      full_seen++;
        ST_EMPTY:     empty_seen++;
        ST_EXTRACTED: extract_seen++;
        default: ;
      endcase
      if (got.status !== exp.status || got.out_id !== exp.out_id ||
          got.out_priority !== exp.out_priority || got.occupancy !== exp.occupancy ||
          got.last !== exp.last)
        note_fault($sformatf({"word mismatch: exp st=%0d id=%h pr=%h occ=%0d last=%b",
                              " got st=%0d id=%h pr=%h occ=%0d last=%b"},
                             exp.status, exp.out_id, exp.out_priority, exp.occupancy,
                             exp.last, got.status, got.out_id, got.out_priority,
                             got.occupancy, got.last));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) check_word(rsp_o);
      if (start && !busy) queue_request(req_i);
      if (res_valid_o || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_word(input req_t r);
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    if (r.action != ACT_UNUSED) words_sent++;
  endtask

  task automatic hold_sender(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_t make_req(input logic [1:0] act, input logic [15:0] id,
                                    input logic [7:0] prio);
    req_t r;
    r.action = act;
    r.entry_id = id;
    r.entry_priority = prio;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_queue();
    send_word(make_req(ACT_LIST, 16'h1234, 8'h56));
    send_word(make_req(ACT_EXTRACT, 16'hFFFF, 8'hFF));
    send_word(make_req(ACT_UNUSED, 16'hFFFF, 8'hFF));
    hold_sender(1);
  endtask

  task automatic test_fill_to_full();
    logic [15:0] id;
    logic [7:0] prio;
    for (int i = 0; i < DEPTH; i++) begin
      id = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF :
           (i % 2 == 1) ? (16'hAAAA ^ 16'(i)) : (16'h5555 ^ 16'(i));
      case (i % 4)
        0: prio = 8'hFF;
        1: prio = 8'h00;
        2: prio = 8'h80;
        default: prio = 8'h00;
      endcase
      send_word(make_req(ACT_INSERT, id, prio));
    end
    send_word(make_req(ACT_INSERT, 16'hBEEF, 8'h00));
    send_word(make_req(ACT_LIST, 16'h0000, 8'h00));
    hold_sender(1);
  endtask

  task automatic test_priority_ties();
    send_word(make_req(ACT_EXTRACT, 16'h0000, 8'h00));
    send_word(make_req(ACT_EXTRACT, 16'h0000, 8'h00));
    hold_sender(1);
  endtask

  task automatic test_pause_for_results();
    hold_sender(1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items);
    int target;
    int phase_left;
    int p;
    bit filling;
    bit quiet;
    req_t r;
    target = words_sent + n_items;
    phase_left = 0;
    filling = 1'b0;
    quiet = 1'b0;
    while (words_sent < target) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(12, 30);
        filling = !filling;
        quiet = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      p = $urandom_range(0, 99);
      if (p < 5) r.action = ACT_UNUSED;
      else if (p < (filling ? 62 : 30)) r.action = ACT_INSERT;
      else if (p < 82) r.action = ACT_EXTRACT;
      else r.action = ACT_LIST;
      r.entry_id = 16'($urandom);
      p = $urandom_range(0, 9);
      if (p < 4) r.entry_priority = 8'($urandom_range(0, 3));
      else if (p == 4) r.entry_priority = 8'hFF;
      else r.entry_priority = 8'($urandom);
      send_word(r);
      hold_sender(quiet ? 0 : gap_len());
    end
    hold_sender(1);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_queue();
    test_fill_to_full();
    test_priority_ties();
    test_pause_for_results();
    test_random_traffic(80);
    test_pause_for_results();
    test_random_traffic(80);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests, %0d words checked", words_sent, words_checked);
    $display("extracts %0d, full rejects %0d, empty replies %0d, longest list %0d",
             extract_seen, full_seen, empty_seen, longest_list);
    if (fault_count == 0 && pending_words.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
